@@ design/att_pkg.sv @@
// Shared types, widths and codes for the audio timestamp tracker.
`default_nettype none

package att_pkg;

    localparam int TS_W           = 32;
    localparam int PLEN_W         = 16;
    localparam int CONS_W         = 13;
    localparam int QCNT_W         = 7;
    localparam int BYTES_W        = 17;
    localparam int PROD_W         = TS_W + PLEN_W;
    localparam int FIFO_DEPTH_DEF = 64;
    localparam int DIV_BITS       = 4;
    localparam int DIV_STEPS      = TS_W / DIV_BITS;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_CONSUME = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_SEEK    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_HEAD,
        ST_NEXT,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec_simple;
        logic cons_start;
        logic head_eval;
        logic diff_load;
        logic div_start;
        logic interp_write;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic count_zero;
        logic count_one;
        logic head_pop;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ design/att_in_if.sv @@
// Input channel interface: one command transaction per handshake.
`default_nettype none

interface att_in_if;
    logic                          valid;
    logic                          ready;
    att_pkg::t_op                  operation;
    logic [att_pkg::TS_W-1:0]      timestamp_ms;
    logic [att_pkg::PLEN_W-1:0]    packet_bytes;
    logic [att_pkg::CONS_W-1:0]    consumed_bytes;

    modport source (
        output valid, operation, timestamp_ms, packet_bytes, consumed_bytes,
        input  ready
    );
    modport sink (
        input  valid, operation, timestamp_ms, packet_bytes, consumed_bytes,
        output ready
    );
endinterface

`default_nettype wire

@@ design/att_out_if.sv @@
// Result channel interface: one status transaction per command.
`default_nettype none

interface att_out_if;
    logic                          valid;
    logic                          ready;
    logic [att_pkg::TS_W-1:0]      current_timestamp;
    logic [att_pkg::QCNT_W-1:0]    queue_count;
    logic                          dropped;

    modport source (
        output valid, current_timestamp, queue_count, dropped,
        input  ready
    );
    modport sink (
        input  valid, current_timestamp, queue_count, dropped,
        output ready
    );
endinterface

`default_nettype wire

@@ design/att_div.sv @@
// Radix-16 restoring divider for the interpolation quotient.
`default_nettype none

module att_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [att_pkg::PROD_W-1:0]    i_dividend,
    input  wire logic [att_pkg::PLEN_W-1:0]    i_divisor,
    output logic                               o_busy,
    output logic [att_pkg::TS_W-1:0]           o_quotient
);

    localparam int CNT_W = $clog2(att_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(att_pkg::DIV_STEPS - 1);

    logic                         r_busy;
    logic [CNT_W-1:0]             r_cnt;
    logic [att_pkg::PLEN_W-1:0]   r_rem;
    logic [att_pkg::TS_W-1:0]     r_quo;
    logic [att_pkg::PLEN_W-1:0]   n_rem;
    logic [att_pkg::TS_W-1:0]     n_quo;

    // Remainder stays below the divisor, so the top bits of the dividend
    // seed it directly and only the low word is shifted through.
    always_comb begin
        logic [att_pkg::PLEN_W:0] rem_sh;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < att_pkg::DIV_BITS; k++) begin
            rem_sh = {n_rem, n_quo[att_pkg::TS_W-1]};
            n_quo  = {n_quo[att_pkg::TS_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, i_divisor}) begin
                rem_sh   = rem_sh - {1'b0, i_divisor};
                n_quo[0] = 1'b1;
            end
            n_rem = rem_sh[att_pkg::PLEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == LAST_STEP) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[att_pkg::PROD_W-1:att_pkg::TS_W];
            r_quo <= i_dividend[att_pkg::TS_W-1:0];
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ design/att_dpath.sv @@
// Datapath: timestamp FIFO memory, playback counters, interpolation and result register.
`default_nettype none

module att_dpath #(
    parameter int FIFO_DEPTH = att_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire att_pkg::t_cmd                 i_cmd,
    output att_pkg::t_sts                      o_sts,
    input  wire att_pkg::t_op                  i_operation,
    input  wire logic [att_pkg::TS_W-1:0]      i_timestamp_ms,
    input  wire logic [att_pkg::PLEN_W-1:0]    i_packet_bytes,
    input  wire logic [att_pkg::CONS_W-1:0]    i_consumed_bytes,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [att_pkg::TS_W-1:0]           o_current_timestamp,
    output logic [att_pkg::QCNT_W-1:0]         o_queue_count,
    output logic                               o_dropped
);

    localparam int IDX_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int MEM_W = att_pkg::TS_W + att_pkg::PLEN_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

    // latched command
    att_pkg::t_op                 r_op;
    logic [att_pkg::TS_W-1:0]     r_ts;
    logic [att_pkg::PLEN_W-1:0]   r_plen;
    logic [att_pkg::CONS_W-1:0]   r_cons;
    logic                         r_dropped;

    // tracker state
    logic [IDX_W-1:0]             r_head, n_head;
    logic [IDX_W-1:0]             r_tail, n_tail;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [att_pkg::BYTES_W-1:0]  r_bytes, n_bytes;
    logic [att_pkg::TS_W-1:0]     r_now, n_now;

    // interpolation operands
    logic [att_pkg::TS_W-1:0]     r_t0;
    logic [att_pkg::PLEN_W-1:0]   r_len;
    logic [att_pkg::TS_W-1:0]     r_diff;
    logic                         r_neg;

    // FIFO storage
    logic [MEM_W-1:0]             r_mem [FIFO_DEPTH];
    logic [MEM_W-1:0]             r_rd_data;

    // result register
    logic                         r_out_valid;
    logic [att_pkg::TS_W-1:0]     r_out_ts;
    logic [att_pkg::QCNT_W-1:0]   r_out_cnt;
    logic                         r_out_drop;

    logic [IDX_W-1:0]             head_next;
    logic [IDX_W-1:0]             tail_next;
    logic [IDX_W-1:0]             rd_addr;
    logic [att_pkg::PLEN_W-1:0]   rd_len;
    logic [att_pkg::TS_W-1:0]     rd_time;
    logic                         full;
    logic                         push_ok;
    logic                         push_drop;
    logic                         mem_we;
    logic                         head_pop;
    logic                         count_zero;
    logic                         count_one;
    logic [att_pkg::PROD_W-1:0]   product;
    logic                         div_busy;
    logic [att_pkg::TS_W-1:0]     quo;

    assign head_next  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_next  = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign rd_len     = r_rd_data[att_pkg::PLEN_W-1:0];
    assign rd_time    = r_rd_data[MEM_W-1:att_pkg::PLEN_W];
    assign full       = (r_count == FULL_CNT);
    assign push_ok    = (r_op == att_pkg::OP_PUSH) && (r_plen != '0) && !full;
    assign push_drop  = (r_op == att_pkg::OP_PUSH) && (r_plen != '0) && full;
    assign mem_we     = i_cmd.exec_simple && push_ok;
    assign head_pop   = (r_bytes >= att_pkg::BYTES_W'(rd_len));
    assign count_zero = (r_count == '0);
    assign count_one  = (r_count == CNT_W'(1));
    // First read fetches the head; every later read fetches the slot after it.
    assign rd_addr    = i_cmd.cons_start ? r_head : head_next;
    assign product    = att_pkg::PROD_W'(r_diff)
                      * att_pkg::PROD_W'(r_bytes[att_pkg::PLEN_W-1:0]);

    att_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (product),
        .i_divisor  (r_len),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= {r_ts, r_plen};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_bytes = r_bytes;
        n_now   = r_now;
        if (i_cmd.exec_simple) begin
            case (r_op)
                att_pkg::OP_PUSH: begin
                    if (push_ok) begin
                        n_tail  = tail_next;
                        n_count = r_count + 1'b1;
                    end
                end
                att_pkg::OP_CLEAR: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                    n_bytes = '0;
                    n_now   = '0;
                end
                att_pkg::OP_SEEK: begin
                    n_now = r_ts;
                end
                default: ;
            endcase
        end
        if (i_cmd.cons_start) begin
            n_bytes = count_zero ? '0 : r_bytes + att_pkg::BYTES_W'(r_cons);
        end
        if (i_cmd.head_eval) begin
            if (head_pop) begin
                n_now   = rd_time;
                n_head  = head_next;
                n_count = r_count - 1'b1;
                n_bytes = count_one ? '0 : r_bytes - att_pkg::BYTES_W'(rd_len);
            end else if (count_one) begin
                n_now = rd_time;
            end
        end
        if (i_cmd.interp_write) begin
            n_now = r_neg ? r_t0 - quo : r_t0 + quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_bytes     <= '0;
            r_now       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_bytes <= n_bytes;
            r_now   <= n_now;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op      <= i_operation;
            r_ts      <= i_timestamp_ms;
            r_plen    <= i_packet_bytes;
            r_cons    <= i_consumed_bytes;
            r_dropped <= 1'b0;
        end else if (i_cmd.exec_simple) begin
            r_dropped <= push_drop;
        end
        if (i_cmd.head_eval && !head_pop) begin
            r_t0  <= rd_time;
            r_len <= rd_len;
        end
        if (i_cmd.diff_load) begin
            if (rd_time >= r_t0) begin
                r_diff <= rd_time - r_t0;
                r_neg  <= 1'b0;
            end else begin
                r_diff <= r_t0 - rd_time;
                r_neg  <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_out_ts   <= r_now;
            r_out_cnt  <= att_pkg::QCNT_W'(r_count);
            r_out_drop <= r_dropped;
        end
    end

    always_comb begin
        o_sts.op         = r_op;
        o_sts.count_zero = count_zero;
        o_sts.count_one  = count_one;
        o_sts.head_pop   = head_pop;
        o_sts.div_busy   = div_busy;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid         = r_out_valid;
    assign o_current_timestamp = r_out_ts;
    assign o_queue_count       = r_out_cnt;
    assign o_dropped           = r_out_drop;

endmodule

`default_nettype wire

@@ design/att_ctrl.sv @@
// Controller: sequences one command transaction at a time through the datapath.
`default_nettype none

module att_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire att_pkg::t_sts   i_sts,
    output att_pkg::t_cmd        o_cmd
);

    att_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= att_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            att_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = att_pkg::ST_DECODE;
                end
            end
            att_pkg::ST_DECODE: begin
                if (i_sts.op == att_pkg::OP_CONSUME) begin
                    o_cmd.cons_start = 1'b1;
                    n_state = i_sts.count_zero ? att_pkg::ST_DONE : att_pkg::ST_HEAD;
                end else begin
                    o_cmd.exec_simple = 1'b1;
                    n_state           = att_pkg::ST_DONE;
                end
            end
            att_pkg::ST_HEAD: begin
                // pop a fully played head, settle on the last entry, or go on to interpolate
                o_cmd.head_eval = 1'b1;
                if (i_sts.count_one) begin
                    n_state = att_pkg::ST_DONE;
                end else if (i_sts.head_pop) begin
                    n_state = att_pkg::ST_HEAD;
                end else begin
                    n_state = att_pkg::ST_NEXT;
                end
            end
            att_pkg::ST_NEXT: begin
                o_cmd.diff_load = 1'b1;
                n_state         = att_pkg::ST_MUL;
            end
            att_pkg::ST_MUL: begin
                o_cmd.div_start = 1'b1;
                n_state         = att_pkg::ST_DIV;
            end
            att_pkg::ST_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = att_pkg::ST_FIN;
                end
            end
            att_pkg::ST_FIN: begin
                o_cmd.interp_write = 1'b1;
                n_state            = att_pkg::ST_DONE;
            end
            att_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = att_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = att_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == att_pkg::ST_IDLE);

endmodule

`default_nettype wire

@@ design/audio_timestamp_tracker_core.sv @@
// Top level of the audio timestamp tracker: controller, datapath and checks.
//
//  Port    | Dir | Transaction                           | Payload
//  --------+-----+---------------------------------------+---------------------------------
//  i_in    | in  | push, consume, clear or seek command  | operation, timestamp_ms,
//          |     |                                       | packet_bytes, consumed_bytes
//  o_out   | out | state after the command               | current_timestamp, queue_count,
//          |     |                                       | dropped
//
//  Push, clear, seek and empty-FIFO consume go from decode straight to the result register.
//  Consume pops each fully played head, at one FIFO read each, and then either empties the
//  FIFO, settles on the one entry left, or interpolates between two entries; the divide
//  retires 4 quotient bits per cycle. One command is in flight at a time; the next is
//  taken once the result is registered, even while o_out is still stalled. Synchronous
//  active-low reset empties the FIFO and zeroes the time; FIFO entries are read once written.
`default_nettype none

module audio_timestamp_tracker_core #(
    parameter int FIFO_DEPTH = att_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    att_in_if.sink      i_in,
    att_out_if.source   o_out
);

    att_pkg::t_cmd cmd;
    att_pkg::t_sts sts;
    logic          in_ready;

    // sequence one command transaction at a time
    att_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // hold FIFO, time and byte count; drive the result register
    att_dpath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_operation         (i_in.operation),
        .i_timestamp_ms      (i_in.timestamp_ms),
        .i_packet_bytes      (i_in.packet_bytes),
        .i_consumed_bytes    (i_in.consumed_bytes),
        .o_out_valid         (o_out.valid),
        .i_out_ready         (o_out.ready),
        .o_current_timestamp (o_out.current_timestamp),
        .o_queue_count       (o_out.queue_count),
        .o_dropped           (o_out.dropped)
    );

    assign i_in.ready = in_ready;

`ifndef SYNTHESIS
    // an accepted command lowers ready in the following cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("command accepted while another is in flight");

    // a new result never overwrites one the sink has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("result register reloaded while stalled");

    // only a push can report a drop
    a_drop_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load && sts.op != att_pkg::OP_PUSH) |=> !o_out.dropped)
        else $error("drop flagged for a non-push command");
`endif

endmodule

`default_nettype wire
